// ----- rtl/md5_pkg.sv -----
package md5_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_ZERO,
		ST_OUT
	} state_t;

	// which block the compressor is working on
	typedef enum logic [1:0] {
		BLK_DATA,
		BLK_PAD,
		BLK_LAST
	} blk_kind_t;

	localparam logic [31:0] InitChain [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [31:0] RoundK [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] RotAmt [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] dbl;
		dbl = {v, v} << s;
		return dbl[63:32];
	endfunction

	// message word used by round rnd
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] lo;
		logic [3:0] g;
		lo = rnd[3:0];
		case (rnd[5:4])
			2'd0: g = lo;
			2'd1: g = 4'(lo * 4'd5 + 4'd1);
			2'd2: g = 4'(lo * 4'd3 + 4'd5);
			2'd3: g = 4'(lo * 4'd7);
			default: g = lo;
		endcase
		return g;
	endfunction

endpackage

// ----- rtl/md5_ifs.sv -----
interface md5_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output has_byte,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input end_of_message, output ready);
endinterface

interface md5_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

// ----- rtl/md5_stream_hasher.sv -----
// MD5 digest over a byte stream.
// byte_ch: one beat per item; has_byte marks data_byte as message data,
//   end_of_message closes the message after that beat's byte.
// digest_ch: four beats per message, words A..D (word_index 0..3), each word
//   little-endian in RFC byte order; last_word is set on the fourth.
// Throughput: byte_ch takes one beat per cycle while the hasher is idle.
//   The 64th byte of a block starts a compression (load, 64 rounds, chain
//   update), during which byte_ch is not ready.
//   The rounds run one per cycle through a single round unit fed from the
//   16-word block memory by its one read port.
// After end_of_message come a padding sweep and a compression, plus a
//   length block and compression when at most 8 bytes of the last block are
//   free, and a compression first when the closing byte fills a block.
// The block holds one message at a time; while the digest waits on a
//   stalled receiver no byte beat is taken. After the fourth beat the chain
//   and byte count return to their initial values.
// Reset puts the hasher in its initial state, ready for a new message;
//   the block memory needs no clearing.
module md5_stream_hasher (
	input  logic           clk,
	input  logic           arst_n,
	md5_byte_if.sink       byte_ch,
	md5_digest_if.source   digest_ch
);

	md5_pkg::state_t    state_q, state_d;
	md5_pkg::blk_kind_t kind_q, kind_d;

	logic [5:0]  rnd_q, rnd_d;
	logic [3:0]  w_q, w_d;
	logic [60:0] cnt_q, cnt_d;
	logic        fin_q, fin_d;
	logic [1:0]  oidx_q, oidx_d;
	logic [31:0] ch_q [4];
	logic [31:0] word_q;
	logic [31:0] wa_q, wb_q, wc_q, wd_q;

	logic [31:0] blk_mem [16];
	logic [31:0] rd_q;
	logic        mem_we;
	logic [3:0]  mem_waddr;
	logic [31:0] mem_wdata;
	logic [3:0]  mem_raddr;

	logic        word_we, load_work, do_round, do_fold, chain_init;
	logic [31:0] word_next, pad_word, pad_val, len_val;
	logic [63:0] bit_len;
	logic        extra_blk;
	logic [31:0] f_val, rsum, new_b;

	// byte assembly into the current block word
	always_comb begin
		if (cnt_q[1:0] == 2'd0) begin
			word_next = {24'h0, byte_ch.data_byte};
		end else begin
			word_next = word_q | ({24'h0, byte_ch.data_byte} << {cnt_q[1:0], 3'b000});
		end
	end

	assign bit_len   = {cnt_q, 3'b000};
	assign extra_blk = (cnt_q[5:0] >= 6'd56);

	always_comb begin
		if (cnt_q[1:0] == 2'd0) begin
			pad_word = 32'h0000_0080;
		end else begin
			pad_word = word_q | (32'h0000_0080 << {cnt_q[1:0], 3'b000});
		end
	end

	always_comb begin
		if (w_q == cnt_q[5:2]) begin
			pad_val = pad_word;
		end else if (!extra_blk && w_q == 4'd14) begin
			pad_val = bit_len[31:0];
		end else if (!extra_blk && w_q == 4'd15) begin
			pad_val = bit_len[63:32];
		end else begin
			pad_val = 32'h0;
		end
	end

	always_comb begin
		if (w_q == 4'd14) begin
			len_val = bit_len[31:0];
		end else if (w_q == 4'd15) begin
			len_val = bit_len[63:32];
		end else begin
			len_val = 32'h0;
		end
	end

	// round unit
	always_comb begin
		case (rnd_q[5:4])
			2'd0: f_val = (wb_q & wc_q) | (~wb_q & wd_q);
			2'd1: f_val = (wd_q & wb_q) | (~wd_q & wc_q);
			2'd2: f_val = wb_q ^ wc_q ^ wd_q;
			2'd3: f_val = wc_q ^ (wb_q | ~wd_q);
			default: f_val = 32'h0;
		endcase
		rsum  = wa_q + f_val + md5_pkg::RoundK[rnd_q] + rd_q;
		new_b = wb_q + md5_pkg::rotl(rsum, md5_pkg::RotAmt[{rnd_q[5:4], rnd_q[1:0]}]);
	end

	always_comb begin
		state_d    = state_q;
		kind_d     = kind_q;
		rnd_d      = rnd_q;
		w_d        = w_q;
		cnt_d      = cnt_q;
		fin_d      = fin_q;
		oidx_d     = oidx_q;
		mem_we     = 1'b0;
		mem_waddr  = w_q;
		mem_wdata  = pad_val;
		mem_raddr  = md5_pkg::msg_index(6'(rnd_q + 6'd1));
		word_we    = 1'b0;
		load_work  = 1'b0;
		do_round   = 1'b0;
		do_fold    = 1'b0;
		chain_init = 1'b0;
		byte_ch.ready   = 1'b0;
		digest_ch.valid = 1'b0;
		case (state_q)
			md5_pkg::ST_IDLE: begin
				byte_ch.ready = 1'b1;
				if (byte_ch.valid) begin
					if (byte_ch.has_byte) begin
						mem_we    = 1'b1;
						mem_waddr = cnt_q[5:2];
						mem_wdata = word_next;
						word_we   = 1'b1;
						cnt_d     = cnt_q + 61'd1;
					end
					fin_d = byte_ch.end_of_message;
					if (byte_ch.has_byte && cnt_q[5:0] == 6'h3f) begin
						state_d = md5_pkg::ST_START;
						kind_d  = md5_pkg::BLK_DATA;
					end else if (byte_ch.end_of_message) begin
						state_d = md5_pkg::ST_PAD;
						w_d     = cnt_d[5:2];
					end
				end
			end
			md5_pkg::ST_START: begin
				load_work = 1'b1;
				mem_raddr = md5_pkg::msg_index(6'd0);
				rnd_d     = 6'd0;
				state_d   = md5_pkg::ST_ROUND;
			end
			md5_pkg::ST_ROUND: begin
				do_round = 1'b1;
				rnd_d    = 6'(rnd_q + 6'd1);
				if (rnd_q == 6'd63) begin
					state_d = md5_pkg::ST_FOLD;
				end
			end
			md5_pkg::ST_FOLD: begin
				do_fold = 1'b1;
				case (kind_q)
					md5_pkg::BLK_DATA: begin
						if (fin_q) begin
							state_d = md5_pkg::ST_PAD;
							w_d     = cnt_q[5:2];
						end else begin
							state_d = md5_pkg::ST_IDLE;
						end
					end
					md5_pkg::BLK_PAD: begin
						state_d = md5_pkg::ST_ZERO;
						w_d     = 4'd0;
					end
					md5_pkg::BLK_LAST: begin
						state_d = md5_pkg::ST_OUT;
						oidx_d  = 2'd0;
					end
					default: state_d = md5_pkg::ST_IDLE;
				endcase
			end
			md5_pkg::ST_PAD: begin
				mem_we    = 1'b1;
				mem_wdata = pad_val;
				if (w_q == 4'd15) begin
					state_d = md5_pkg::ST_START;
					kind_d  = extra_blk ? md5_pkg::BLK_PAD : md5_pkg::BLK_LAST;
				end else begin
					w_d = 4'(w_q + 4'd1);
				end
			end
			md5_pkg::ST_ZERO: begin
				mem_we    = 1'b1;
				mem_wdata = len_val;
				if (w_q == 4'd15) begin
					state_d = md5_pkg::ST_START;
					kind_d  = md5_pkg::BLK_LAST;
				end else begin
					w_d = 4'(w_q + 4'd1);
				end
			end
			md5_pkg::ST_OUT: begin
				digest_ch.valid = 1'b1;
				if (digest_ch.ready) begin
					oidx_d = 2'(oidx_q + 2'd1);
					if (oidx_q == 2'd3) begin
						state_d    = md5_pkg::ST_IDLE;
						chain_init = 1'b1;
						cnt_d      = 61'd0;
						fin_d      = 1'b0;
					end
				end
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
	end

	assign digest_ch.digest_word = ch_q[oidx_q];
	assign digest_ch.word_index  = oidx_q;
	assign digest_ch.last_word   = (oidx_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::ST_IDLE;
			kind_q  <= md5_pkg::BLK_DATA;
			rnd_q   <= 6'd0;
			w_q     <= 4'd0;
			cnt_q   <= 61'd0;
			fin_q   <= 1'b0;
			oidx_q  <= 2'd0;
			for (int i = 0; i < 4; i++) begin
				ch_q[i] <= md5_pkg::InitChain[i];
			end
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			rnd_q   <= rnd_d;
			w_q     <= w_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
			oidx_q  <= oidx_d;
			if (chain_init) begin
				for (int i = 0; i < 4; i++) begin
					ch_q[i] <= md5_pkg::InitChain[i];
				end
			end else if (do_fold) begin
				ch_q[0] <= ch_q[0] + wa_q;
				ch_q[1] <= ch_q[1] + wb_q;
				ch_q[2] <= ch_q[2] + wc_q;
				ch_q[3] <= ch_q[3] + wd_q;
			end
		end
	end

	// working variables and byte assembly
	always_ff @(posedge clk) begin
		if (word_we) begin
			word_q <= word_next;
		end
		if (load_work) begin
			wa_q <= ch_q[0];
			wb_q <= ch_q[1];
			wc_q <= ch_q[2];
			wd_q <= ch_q[3];
		end else if (do_round) begin
			wa_q <= wd_q;
			wd_q <= wc_q;
			wc_q <= wb_q;
			wb_q <= new_b;
		end
	end

	// block buffer, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			blk_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= blk_mem[mem_raddr];
	end

endmodule
